[src/ialu_pkg.sv]
package ialu_pkg;

    localparam logic [4:0] ACT_ADD      = 5'd0;
    localparam logic [4:0] ACT_ADD_C    = 5'd1;
    localparam logic [4:0] ACT_ADD_NC   = 5'd2;
    localparam logic [4:0] ACT_ADD_CNC  = 5'd3;
    localparam logic [4:0] ACT_SUB      = 5'd4;
    localparam logic [4:0] ACT_SUB_C    = 5'd5;
    localparam logic [4:0] ACT_SUB_NC   = 5'd6;
    localparam logic [4:0] ACT_NEG      = 5'd7;
    localparam logic [4:0] ACT_EQ       = 5'd8;
    localparam logic [4:0] ACT_NE       = 5'd9;
    localparam logic [4:0] ACT_LE_U     = 5'd10;
    localparam logic [4:0] ACT_GT_U     = 5'd11;
    localparam logic [4:0] ACT_GE_U     = 5'd12;
    localparam logic [4:0] ACT_LT_U     = 5'd13;
    localparam logic [4:0] ACT_LE_S     = 5'd14;
    localparam logic [4:0] ACT_GT_S     = 5'd15;
    localparam logic [4:0] ACT_GE_S     = 5'd16;
    localparam logic [4:0] ACT_LT_S     = 5'd17;
    localparam logic [4:0] ACT_MUL_LOW  = 5'd18;
    localparam logic [4:0] ACT_MUL_FULL = 5'd19;
    localparam logic [4:0] ACT_DIV_U    = 5'd20;
    localparam logic [4:0] ACT_SHL      = 5'd21;
    localparam logic [4:0] ACT_SHR_L    = 5'd22;
    localparam logic [4:0] ACT_SHR_A    = 5'd23;
    localparam logic [4:0] ACT_SWAP     = 5'd24;

    localparam int FIELD_W = 16;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ITER   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic iter;
    } status_t;

endpackage

[src/integer_alu_with_divider.sv]
// channel | dir | tdata fields, lowest bit up
// s_axis  | in  | action[4:0] operand_a[20:5] operand_b[36:21] shift_amount[44:37]
//         |     | swap_condition[45] zero[47:46]
// m_axis  | out | result_low[15:0] result_high[31:16] compare_flag[32] carry_flag[33]
//         |     | zero[39:34]
// multiply and divide: one shift-add or restore step of the shared
// accumulator each cycle, between load and result
// all other actions: load, then result
// reset clears the carry flag, the sequencer and the output valid
// a stalled output word holds while the next input word is taken and worked
module integer_alu_with_divider #(
    parameter int WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // action, operand_a, operand_b, shift_amount, swap_condition
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // result_low, result_high, compare_flag, carry_flag
);

    ialu_pkg::cmd_t    cmd;
    ialu_pkg::status_t status;
    logic [15:0]       result_low, result_high;
    logic              compare_flag, carry_flag;

    ialu_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ialu_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (s_tdata[4:0]),
        .operand_a      (s_tdata[20:5]),
        .operand_b      (s_tdata[36:21]),
        .shift_amount   (s_tdata[44:37]),
        .swap_condition (s_tdata[45]),
        .cmd            (cmd),
        .status         (status),
        .result_low     (result_low),
        .result_high    (result_high),
        .compare_flag   (compare_flag),
        .carry_flag     (carry_flag)
    );

    assign m_tdata = {6'b000000, carry_flag, compare_flag, result_high, result_low};

endmodule

[src/ialu_ctrl.sv]
module ialu_ctrl #(
    parameter int WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ialu_pkg::status_t status,
    output ialu_pkg::cmd_t    cmd
);

    localparam int CW = $clog2(WIDTH + 1);

    ialu_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;
    logic             slot_free;

    assign s_tready  = (state_reg == ialu_pkg::S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ialu_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (status.iter)
                    begin
                        state_next = ialu_pkg::S_ITER;
                        cnt_next   = CW'(WIDTH);
                    end
                    else
                    begin
                        state_next = ialu_pkg::S_FINISH;
                    end
                end
            end
            ialu_pkg::S_ITER:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ialu_pkg::S_FINISH;
                end
            end
            ialu_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ialu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ialu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ialu_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ialu_pkg::S_ITER |-> cnt_reg != '0)
        else $error("iteration without remaining count");

    a_simple_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !status.iter) |=> state_reg == ialu_pkg::S_FINISH)
        else $error("single-step word did not go to finish");

    a_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> slot_free)
        else $error("output register loaded while occupied");

endmodule

[src/ialu_dp.sv]
module ialu_dp #(
    parameter int WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [4:0]                    action,
    input  logic [ialu_pkg::FIELD_W-1:0]  operand_a,
    input  logic [ialu_pkg::FIELD_W-1:0]  operand_b,
    input  logic [7:0]                    shift_amount,
    input  logic                          swap_condition,
    input  ialu_pkg::cmd_t                cmd,
    output ialu_pkg::status_t             status,
    output logic [ialu_pkg::FIELD_W-1:0]  result_low,
    output logic [ialu_pkg::FIELD_W-1:0]  result_high,
    output logic                          compare_flag,
    output logic                          carry_flag
);

    localparam int W  = WIDTH;
    localparam int FW = ialu_pkg::FIELD_W;

    logic [4:0]    act_reg;
    logic [W-1:0]  a_reg, b_reg, acc_reg, q_reg;
    logic [7:0]    sh_reg;
    logic          cond_reg;
    logic          carry_reg;

    logic [FW-1:0] low_reg, high_reg;
    logic          cmp_reg;

    logic [W+FW-1:0] a_ext, b_ext;
    logic [W:0]      msum;
    logic [W:0]      mq_tmp;
    logic [W:0]      dshift;
    logic [W+1:0]    trial;
    logic            dge;
    logic [W:0]      dq_tmp;
    logic [W-1:0]    acc_next, q_next;

    logic [W-1:0]    bx;
    logic            cin;
    logic [W:0]      sum_w;
    logic            c_top;
    logic [W-1:0]    res_lo, res_hi;
    logic            res_cmp;
    logic            carry_next;
    logic [W+FW-1:0] lo_ext, hi_ext;

    assign a_ext = {{W{1'b0}}, operand_a};
    assign b_ext = {{W{1'b0}}, operand_b};

    assign status.iter = (action == ialu_pkg::ACT_MUL_LOW) ||
                         (action == ialu_pkg::ACT_MUL_FULL) ||
                         (action == ialu_pkg::ACT_DIV_U);

    // shift-add multiply step and restoring divide step
    always_comb
    begin
        msum   = q_reg[0] ? ({1'b0, acc_reg} + {1'b0, b_reg}) : {1'b0, acc_reg};
        mq_tmp = {msum[0], q_reg};
        dshift = {acc_reg, q_reg[W-1]};
        trial  = {1'b0, dshift} - {2'b00, b_reg};
        dge    = !trial[W+1];
        dq_tmp = {q_reg, dge};
        if (act_reg == ialu_pkg::ACT_DIV_U)
        begin
            acc_next = dge ? trial[W-1:0] : dshift[W-1:0];
            q_next   = dq_tmp[W-1:0];
        end
        else
        begin
            acc_next = msum[W:1];
            q_next   = mq_tmp[W:1];
        end
    end

    always_comb
    begin
        bx = ((act_reg == ialu_pkg::ACT_SUB) || (act_reg == ialu_pkg::ACT_SUB_C) ||
              (act_reg == ialu_pkg::ACT_SUB_NC)) ? ~b_reg : b_reg;
        case (act_reg) inside
            ialu_pkg::ACT_ADD_C, ialu_pkg::ACT_ADD_CNC, ialu_pkg::ACT_SUB_C:
                cin = carry_reg;
            ialu_pkg::ACT_SUB, ialu_pkg::ACT_SUB_NC:
                cin = 1'b1;
            default:
                cin = 1'b0;
        endcase
        sum_w = {1'b0, a_reg} + {1'b0, bx} + {{W{1'b0}}, cin};
        c_top = a_reg[W-1] ^ bx[W-1] ^ sum_w[W-1];

        res_lo     = '0;
        res_hi     = '0;
        res_cmp    = 1'b0;
        carry_next = carry_reg;
        unique case (act_reg) inside
            ialu_pkg::ACT_ADD, ialu_pkg::ACT_ADD_C, ialu_pkg::ACT_SUB,
            ialu_pkg::ACT_SUB_C:
            begin
                res_lo     = sum_w[W-1:0];
                carry_next = sum_w[W];
            end
            ialu_pkg::ACT_ADD_NC, ialu_pkg::ACT_ADD_CNC, ialu_pkg::ACT_SUB_NC:
            begin
                res_lo     = sum_w[W-1:0];
                carry_next = c_top;
            end
            ialu_pkg::ACT_NEG:      res_lo  = -a_reg;
            ialu_pkg::ACT_EQ:       res_cmp = (a_reg == b_reg);
            ialu_pkg::ACT_NE:       res_cmp = (a_reg != b_reg);
            ialu_pkg::ACT_LE_U:     res_cmp = (a_reg <= b_reg);
            ialu_pkg::ACT_GT_U:     res_cmp = (a_reg > b_reg);
            ialu_pkg::ACT_GE_U:     res_cmp = (a_reg >= b_reg);
            ialu_pkg::ACT_LT_U:     res_cmp = (a_reg < b_reg);
            ialu_pkg::ACT_LE_S:     res_cmp = ($signed(a_reg) <= $signed(b_reg));
            ialu_pkg::ACT_GT_S:     res_cmp = ($signed(a_reg) > $signed(b_reg));
            ialu_pkg::ACT_GE_S:     res_cmp = ($signed(a_reg) >= $signed(b_reg));
            ialu_pkg::ACT_LT_S:     res_cmp = ($signed(a_reg) < $signed(b_reg));
            ialu_pkg::ACT_MUL_LOW:  res_lo  = q_reg;
            ialu_pkg::ACT_MUL_FULL, ialu_pkg::ACT_DIV_U:
            begin
                res_lo = q_reg;
                res_hi = acc_reg;
            end
            ialu_pkg::ACT_SHL:      res_lo  = a_reg << sh_reg;
            ialu_pkg::ACT_SHR_L:    res_lo  = a_reg >> sh_reg;
            ialu_pkg::ACT_SHR_A:    res_lo  = W'($signed(a_reg) >>> sh_reg);
            ialu_pkg::ACT_SWAP:
            begin
                res_lo = cond_reg ? b_reg : a_reg;
                res_hi = cond_reg ? a_reg : b_reg;
            end
            default:
            begin
                res_lo = '0;
            end
        endcase
        lo_ext = {{FW{1'b0}}, res_lo};
        hi_ext = {{FW{1'b0}}, res_hi};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            a_reg    <= a_ext[W-1:0];
            b_reg    <= b_ext[W-1:0];
            sh_reg   <= shift_amount;
            cond_reg <= swap_condition;
            acc_reg  <= '0;
            q_reg    <= a_ext[W-1:0];
        end
        else if (cmd.step)
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
        end
        if (cmd.out_load)
        begin
            low_reg  <= lo_ext[FW-1:0];
            high_reg <= hi_ext[FW-1:0];
            cmp_reg  <= res_cmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            carry_reg <= carry_next;
        end
    end

    assign result_low   = low_reg;
    assign result_high  = high_reg;
    assign compare_flag = cmp_reg;
    assign carry_flag   = carry_reg;

    a_carry_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.out_load |=> $stable(carry_reg))
        else $error("carry flag changed outside result load");

    a_no_load_while_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.step))
        else $error("operand load during iteration");

    a_muldiv_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && ((act_reg == ialu_pkg::ACT_MUL_LOW) ||
                          (act_reg == ialu_pkg::ACT_MUL_FULL) ||
                          (act_reg == ialu_pkg::ACT_DIV_U))) |=> $stable(carry_reg))
        else $error("multiply or divide touched carry flag");

endmodule

[bench/tb.sv]
module tb;

    localparam int RANDOM_OPS  = 424;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_EVERY  = 200;

    // no operation is defined for codes above swap
    localparam logic [4:0] ACT_UNUSED_TOP = 5'd31;

    // packed so that {2'b00, alu_op_t} is the input word
    typedef struct packed {
        logic        swap;
        logic [7:0]  shamt;
        logic [15:0] b;
        logic [15:0] a;
        logic [4:0]  action;
    } alu_op_t;

    // packed so that alu_res_t is the low 34 bits of the output word
    typedef struct packed {
        logic        cy;
        logic        cmp;
        logic [15:0] hi;
        logic [15:0] lo;
    } alu_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    alu_op_t  op_queue[$];
    alu_res_t alu_results_due[$];
    alu_op_t  tx_op;
    alu_res_t rx_want;
    alu_res_t rx_got;
    logic     carry_q = 1'b0;
    bit       tx_quiet = 1'b0;
    bit       rx_quiet = 1'b0;
    int       send_wait = 0;
    int       recv_wait = 0;
    int       words_in = 0;
    int       total_ops = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       hold_cnt = 0;
    int       next_hold_at = 100;

    integer_alu_with_divider #(
        .WIDTH(ialu_pkg::FIELD_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic alu_res_t alu_compute(alu_op_t op);
        alu_res_t    r;
        logic [15:0] addend;
        logic [16:0] sum;
        logic [31:0] prod;
        logic [7:0]  sh_sat;
        logic        cin;
        logic        top_c;
        r = '0;
        sh_sat = (op.shamt > 8'd16) ? 8'd16 : op.shamt;
        addend = (op.action inside {ialu_pkg::ACT_SUB, ialu_pkg::ACT_SUB_C,
                                    ialu_pkg::ACT_SUB_NC}) ? ~op.b : op.b;
        case (op.action) inside
            ialu_pkg::ACT_ADD_C, ialu_pkg::ACT_ADD_CNC, ialu_pkg::ACT_SUB_C:
                cin = carry_q;
            ialu_pkg::ACT_SUB, ialu_pkg::ACT_SUB_NC:
                cin = 1'b1;
            default:
                cin = 1'b0;
        endcase
        sum = {1'b0, op.a} + {1'b0, addend} + {16'd0, cin};
        top_c = op.a[15] ^ addend[15] ^ sum[15];
        prod = {16'd0, op.a} * {16'd0, op.b};
        case (op.action) inside
            ialu_pkg::ACT_ADD, ialu_pkg::ACT_ADD_C, ialu_pkg::ACT_SUB, ialu_pkg::ACT_SUB_C:
            begin
                r.lo = sum[15:0];
                carry_q = sum[16];
            end
            ialu_pkg::ACT_ADD_NC, ialu_pkg::ACT_ADD_CNC, ialu_pkg::ACT_SUB_NC:
            begin
                r.lo = sum[15:0];
                carry_q = top_c;
            end
            ialu_pkg::ACT_NEG:      r.lo = 16'd0 - op.a;
            ialu_pkg::ACT_EQ:       r.cmp = (op.a == op.b);
            ialu_pkg::ACT_NE:       r.cmp = (op.a != op.b);
            ialu_pkg::ACT_LE_U:     r.cmp = (op.a <= op.b);
            ialu_pkg::ACT_GT_U:     r.cmp = (op.a > op.b);
            ialu_pkg::ACT_GE_U:     r.cmp = (op.a >= op.b);
            ialu_pkg::ACT_LT_U:     r.cmp = (op.a < op.b);
            ialu_pkg::ACT_LE_S:     r.cmp = ($signed(op.a) <= $signed(op.b));
            ialu_pkg::ACT_GT_S:     r.cmp = ($signed(op.a) > $signed(op.b));
            ialu_pkg::ACT_GE_S:     r.cmp = ($signed(op.a) >= $signed(op.b));
            ialu_pkg::ACT_LT_S:     r.cmp = ($signed(op.a) < $signed(op.b));
            ialu_pkg::ACT_MUL_LOW:  r.lo = prod[15:0];
            ialu_pkg::ACT_MUL_FULL:
            begin
                r.lo = prod[15:0];
                r.hi = prod[31:16];
            end
            ialu_pkg::ACT_DIV_U:
            begin
                if (op.b == 16'd0)
                begin
                    r.lo = 16'hFFFF;
                    r.hi = op.a;
                end
                else
                begin
                    r.lo = op.a / op.b;
                    r.hi = op.a % op.b;
                end
            end
            ialu_pkg::ACT_SHL:      r.lo = (sh_sat >= 8'd16) ? 16'd0 : (op.a << sh_sat);
            ialu_pkg::ACT_SHR_L:    r.lo = (sh_sat >= 8'd16) ? 16'd0 : (op.a >> sh_sat);
            ialu_pkg::ACT_SHR_A:
                r.lo = (sh_sat >= 8'd16) ? {16{op.a[15]}}
                                         : 16'($signed(op.a) >>> sh_sat);
            ialu_pkg::ACT_SWAP:
            begin
                r.lo = op.swap ? op.b : op.a;
                r.hi = op.swap ? op.a : op.b;
            end
            default: ;
        endcase
        r.cy = carry_q;
        return r;
    endfunction

    function automatic void add_op(logic [4:0] action, logic [15:0] a, logic [15:0] b,
                                   logic [7:0] shamt, logic swap);
        alu_op_t op;
        op.action = action;
        op.a = a;
        op.b = b;
        op.shamt = shamt;
        op.swap = swap;
        op_queue.push_back(op);
    endfunction

    // corner values show up often so carries, signs and zero divisors are hit
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        logic [4:0] act;
        add_op(ialu_pkg::ACT_ADD, 16'hFFFF, 16'h0001, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_ADD_C, 16'h0000, 16'h0000, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_ADD_NC, 16'h7FFF, 16'h0001, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_ADD_CNC, 16'hFFFF, 16'h0000, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_SUB, 16'h0000, 16'h0001, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_SUB_C, 16'h0005, 16'h0003, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_SUB_NC, 16'h8000, 16'h0001, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_NEG, 16'h8000, 16'hFFFF, 8'd0, 1'b0);
        for (int c = ialu_pkg::ACT_EQ; c <= ialu_pkg::ACT_LT_S; c++)
            add_op(5'(c), 16'h8000, 16'h7FFF, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_EQ, 16'h1234, 16'h1234, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_MUL_FULL, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_DIV_U, 16'h1234, 16'h0000, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_DIV_U, 16'hFFFF, 16'h0007, 8'd0, 1'b0);
        add_op(ialu_pkg::ACT_SHL, 16'hFFFF, 16'h0000, 8'd255, 1'b0);
        add_op(ialu_pkg::ACT_SHR_L, 16'hFFFF, 16'h0000, 8'd16, 1'b0);
        add_op(ialu_pkg::ACT_SHR_A, 16'h8000, 16'h0000, 8'd200, 1'b0);
        add_op(ialu_pkg::ACT_SWAP, 16'hAAAA, 16'h5555, 8'd0, 1'b1);
        add_op(ACT_UNUSED_TOP, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                act = 5'($urandom_range(0, 31));
            else
                act = 5'($urandom_range(ialu_pkg::ACT_ADD, ialu_pkg::ACT_SWAP));
            add_op(act, pick_operand(), pick_operand(),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 17)),
                   1'($urandom_range(0, 1)));
        end
        total_ops = op_queue.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in != total_ops || alu_results_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && alu_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            words_in <= 0;
            send_wait = 0;
            carry_q = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                alu_results_due.push_back(alu_compute(tx_op));
                words_in <= words_in + 1;
                if ($urandom_range(0, 31) == 0)
                    tx_quiet = !tx_quiet;
                send_wait = tx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait != 0 || op_queue.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (send_wait != 0)
                        send_wait--;
                end
                else
                begin
                    tx_op = op_queue.pop_front();
                    s_tdata <= {2'b00, tx_op};
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // long output back-pressure so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            next_hold_at <= 100;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (words_in >= next_hold_at)
        begin
            hold_cnt <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_EVERY;
        end
    end

    // output side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                rx_got = alu_res_t'(m_tdata[33:0]);
                if (alu_results_due.size() == 0)
                begin
                    $error("result word with no operation pending");
                    mismatches++;
                end
                else
                begin
                    rx_want = alu_results_due.pop_front();
                    check_field("result_low", rx_want.lo, rx_got.lo);
                    check_field("result_high", rx_want.hi, rx_got.hi);
                    check_field("compare_flag", 16'(rx_want.cmp), 16'(rx_got.cmp));
                    check_field("carry_flag", 16'(rx_want.cy), 16'(rx_got.cy));
                end
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                recv_wait = rx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (hold_cnt != 0)
                m_tready <= 1'b0;
            else if (recv_wait != 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

[filelist.f]
src/ialu_pkg.sv
src/ialu_ctrl.sv
src/ialu_dp.sv
src/integer_alu_with_divider.sv
bench/tb.sv
